### sv/hzd_pkg.sv
// ----------------------------------------------------------------------------
// hzd_pkg
// Shared types, opcodes and counter helpers for the RV32 hazard NOP inserter.
// ----------------------------------------------------------------------------
`default_nettype none

package hzd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int REG_WIDTH   = 5;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef logic [WORD_WIDTH-1:0]  word_t;
  typedef logic [REG_WIDTH-1:0]   reg_idx_t;

  localparam cnt_t  CNT_MAX  = '1;
  localparam word_t NOP_WORD = 32'h0000_0013;

  localparam logic [6:0] OP_ALU_R  = 7'b0110011;
  localparam logic [6:0] OP_ALU_I  = 7'b0010011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;

  typedef enum logic [2:0] {
    K_NOP,
    K_ALU,
    K_JUMP,
    K_BRANCH,
    K_MEM,
    K_OTHER
  } kind_t;

  // Counter snapshot and control for one accepted instruction.
  typedef struct packed {
    word_t word;
    logic  hazard;
    logic  jump;
    cnt_t  total;
    cnt_t  alu;
    cnt_t  jmp;
    cnt_t  branch;
    cnt_t  memory;
    cnt_t  other;
  } run_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c != CNT_MAX) ? c + cnt_t'(1) : c;
  endfunction

  function automatic field_t to_field(input cnt_t c);
    to_field = field_t'(c);
  endfunction

endpackage

`default_nettype wire

### sv/riscv_hazard_nop_inserter.sv
// ----------------------------------------------------------------------------
// riscv_hazard_nop_inserter
// RV32 data-hazard NOP inserter with saturating instruction class counters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, instr_word): one instruction word per
// transaction. Output channel (out_valid/out_stall): one emitted word per
// transaction with is_inserted, last_of_run and the counter values as of
// that emission.
// Each input yields one to three results: a NOP when its source register
// matches the previous word's destination, the word itself, and a NOP after
// a jump. last_of_run marks the final one.
// An accepted input is held in the run buffer and each of its results is
// registered in the single output register, one result per cycle while
// the receiver does not stall; the next input is taken in the cycle its
// predecessor's last result enters the output register.
// Reset clears the previous word and all counters; the first input after
// reset gets no hazard check. A stalled result holds in the output register
// and the block stalls input once its single run buffer is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_hazard_nop_inserter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hzd_pkg::word_t  instr_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hzd_pkg::word_t       out_word,
  output logic                 is_inserted,
  output logic                 last_of_run,
  output hzd_pkg::field_t      total_count,
  output hzd_pkg::field_t      alu_count,
  output hzd_pkg::field_t      jump_count,
  output hzd_pkg::field_t      branch_count,
  output hzd_pkg::field_t      memory_count,
  output hzd_pkg::field_t      other_count,
  output hzd_pkg::field_t      nop_count
);

  hzd_pkg::run_t run_next;
  logic          load;

  assign load = in_valid && !in_stall;

  hzd_cls u_cls (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .instr_word (instr_word),
    .run_next   (run_next)
  );

  hzd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .run_next     (run_next),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .is_inserted  (is_inserted),
    .last_of_run  (last_of_run),
    .total_count  (total_count),
    .alu_count    (alu_count),
    .jump_count   (jump_count),
    .branch_count (branch_count),
    .memory_count (memory_count),
    .other_count  (other_count),
    .nop_count    (nop_count)
  );

endmodule

`default_nettype wire

### sv/hzd_cls.sv
// ----------------------------------------------------------------------------
// hzd_cls
// Decode, hazard check against the previous word, and class counters.
// ----------------------------------------------------------------------------
`default_nettype none

module hzd_cls (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire hzd_pkg::word_t instr_word,
  output hzd_pkg::run_t      run_next
);

  hzd_pkg::word_t    prev_word;
  logic              prev_valid;
  hzd_pkg::cnt_t     total_ctr;
  hzd_pkg::cnt_t     alu_ctr;
  hzd_pkg::cnt_t     jump_ctr;
  hzd_pkg::cnt_t     branch_ctr;
  hzd_pkg::cnt_t     memory_ctr;
  hzd_pkg::cnt_t     other_ctr;

  hzd_pkg::kind_t    kind;
  hzd_pkg::reg_idx_t rd;
  hzd_pkg::reg_idx_t rs1;
  hzd_pkg::reg_idx_t rs2;
  logic              hazard;

  always_comb begin
    priority if (instr_word == hzd_pkg::NOP_WORD) begin
      kind = hzd_pkg::K_NOP;
    end else if (instr_word[6:0] == hzd_pkg::OP_ALU_R ||
                 instr_word[6:0] == hzd_pkg::OP_ALU_I) begin
      kind = hzd_pkg::K_ALU;
    end else if (instr_word[6:0] == hzd_pkg::OP_JAL ||
                 instr_word[6:0] == hzd_pkg::OP_JALR) begin
      kind = hzd_pkg::K_JUMP;
    end else if (instr_word[6:0] == hzd_pkg::OP_BRANCH) begin
      kind = hzd_pkg::K_BRANCH;
    end else if (instr_word[6:0] == hzd_pkg::OP_LOAD ||
                 instr_word[6:0] == hzd_pkg::OP_STORE) begin
      kind = hzd_pkg::K_MEM;
    end else begin
      kind = hzd_pkg::K_OTHER;
    end
  end

  assign rd     = prev_word[11:7];
  assign rs1    = instr_word[19:15];
  assign rs2    = instr_word[24:20];
  assign hazard = prev_valid &&
                  ((rd == rs1) || (kind != hzd_pkg::K_MEM && rd == rs2));

  always_comb begin
    run_next        = '0;
    run_next.word   = instr_word;
    run_next.hazard = hazard;
    run_next.jump   = (kind == hzd_pkg::K_JUMP);
    run_next.total  = hzd_pkg::sat_inc(total_ctr);
    run_next.alu    = (kind == hzd_pkg::K_ALU)    ? hzd_pkg::sat_inc(alu_ctr)    : alu_ctr;
    run_next.jmp    = (kind == hzd_pkg::K_JUMP)   ? hzd_pkg::sat_inc(jump_ctr)   : jump_ctr;
    run_next.branch = (kind == hzd_pkg::K_BRANCH) ? hzd_pkg::sat_inc(branch_ctr) : branch_ctr;
    run_next.memory = (kind == hzd_pkg::K_MEM)    ? hzd_pkg::sat_inc(memory_ctr) : memory_ctr;
    run_next.other  = (kind == hzd_pkg::K_OTHER)  ? hzd_pkg::sat_inc(other_ctr)  : other_ctr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_word  <= '0;
      prev_valid <= 1'b0;
      total_ctr  <= '0;
      alu_ctr    <= '0;
      jump_ctr   <= '0;
      branch_ctr <= '0;
      memory_ctr <= '0;
      other_ctr  <= '0;
    end else if (load) begin
      prev_word  <= instr_word;
      prev_valid <= 1'b1;
      total_ctr  <= run_next.total;
      alu_ctr    <= run_next.alu;
      jump_ctr   <= run_next.jmp;
      branch_ctr <= run_next.branch;
      memory_ctr <= run_next.memory;
      other_ctr  <= run_next.other;
    end
  end

endmodule

`default_nettype wire

### sv/hzd_emit.sv
// ----------------------------------------------------------------------------
// hzd_emit
// Holds one decoded instruction and sequences its results into the output
// register: optional leading NOP, the word, optional trailing NOP.
// ----------------------------------------------------------------------------
`default_nettype none

module hzd_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hzd_pkg::run_t   run_next,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hzd_pkg::word_t       out_word,
  output logic                 is_inserted,
  output logic                 last_of_run,
  output hzd_pkg::field_t      total_count,
  output hzd_pkg::field_t      alu_count,
  output hzd_pkg::field_t      jump_count,
  output hzd_pkg::field_t      branch_count,
  output hzd_pkg::field_t      memory_count,
  output hzd_pkg::field_t      other_count,
  output hzd_pkg::field_t      nop_count
);

  typedef enum logic [2:0] {
    PH_PRE  = 3'b001,
    PH_WORD = 3'b010,
    PH_POST = 3'b100
  } phase_t;

  hzd_pkg::run_t  run;
  logic           run_valid;
  phase_t         phase;
  phase_t         phase_next;
  hzd_pkg::cnt_t  nop_ctr;
  hzd_pkg::cnt_t  nop_ctr_next;

  logic           load;
  logic           emit_ok;
  logic           emit_last;
  logic           emit_ins;
  hzd_pkg::word_t emit_word;

  assign emit_ok  = run_valid && (!out_valid || !out_stall);
  assign in_stall = run_valid && !(emit_ok && emit_last);
  assign load     = in_valid && !in_stall;

  always_comb begin
    unique case (phase)
      PH_PRE: begin
        emit_word  = hzd_pkg::NOP_WORD;
        emit_ins   = 1'b1;
        emit_last  = 1'b0;
        phase_next = PH_WORD;
      end
      PH_POST: begin
        emit_word  = hzd_pkg::NOP_WORD;
        emit_ins   = 1'b1;
        emit_last  = 1'b1;
        phase_next = PH_POST;
      end
      default: begin
        emit_word  = run.word;
        emit_ins   = 1'b0;
        emit_last  = !run.jump;
        phase_next = PH_POST;
      end
    endcase
  end

  assign nop_ctr_next = (emit_ok && emit_ins) ? hzd_pkg::sat_inc(nop_ctr) : nop_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      phase     <= PH_WORD;
      nop_ctr   <= '0;
      out_valid <= 1'b0;
    end else begin
      nop_ctr <= nop_ctr_next;
      if (load) begin
        run_valid <= 1'b1;
        phase     <= run_next.hazard ? PH_PRE : PH_WORD;
      end else if (emit_ok && emit_last) begin
        run_valid <= 1'b0;
      end else if (emit_ok) begin
        phase <= phase_next;
      end
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_next;
    end
    if (emit_ok) begin
      out_word     <= emit_word;
      is_inserted  <= emit_ins;
      last_of_run  <= emit_last;
      total_count  <= hzd_pkg::to_field(run.total);
      alu_count    <= hzd_pkg::to_field(run.alu);
      jump_count   <= hzd_pkg::to_field(run.jmp);
      branch_count <= hzd_pkg::to_field(run.branch);
      memory_count <= hzd_pkg::to_field(run.memory);
      other_count  <= hzd_pkg::to_field(run.other);
      nop_count    <= hzd_pkg::to_field(nop_ctr_next);
    end
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register not one-hot");

  a_pre_needs_hazard: assert property (@(posedge clk) disable iff (rst)
    run_valid && phase == PH_PRE |-> run.hazard)
    else $error("leading NOP without a hazard");

  a_post_needs_jump: assert property (@(posedge clk) disable iff (rst)
    run_valid && phase == PH_POST |-> run.jump)
    else $error("trailing NOP without a jump");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!run_valid || (emit_ok && emit_last)))
    else $error("new transaction overwrote a run still in progress");

endmodule

`default_nettype wire

### dv/riscv_hazard_nop_inserter_test.sv
// ----------------------------------------------------------------------------
// riscv_hazard_nop_inserter_test
// Self-checking testbench for the RV32 hazard NOP inserter.
// ----------------------------------------------------------------------------
// Sends instruction words through the valid/stall input channel. A local
// model classifies each accepted word, applies the destination-to-source
// hazard rule against the previous word and queues the one to three
// transactions the block must emit, with the saturating counter values of
// each. Every output transaction is compared against the oldest queued one.
// Covers directed corner words, random streams that often draw on a small
// register pool, fully random words and a full drain pause. Sender bursts
// and receiver stalls are randomized.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module riscv_hazard_nop_inserter_test;

  localparam logic [6:0] OP_LUI = 7'b0110111;

  typedef struct packed {
    hzd_pkg::word_t  word;
    logic            ins;
    logic            last;
    hzd_pkg::field_t total;
    hzd_pkg::field_t alu;
    hzd_pkg::field_t jmp;
    hzd_pkg::field_t branch;
    hzd_pkg::field_t memory;
    hzd_pkg::field_t other;
    hzd_pkg::field_t nop;
  } emit_t;

  logic            clk        = 1'b0;
  logic            rst        = 1'b1;
  logic            in_valid   = 1'b0;
  logic            in_stall;
  hzd_pkg::word_t  instr_word = '0;
  logic            out_valid;
  logic            out_stall  = 1'b0;
  hzd_pkg::word_t  out_word;
  logic            is_inserted;
  logic            last_of_run;
  hzd_pkg::field_t total_count;
  hzd_pkg::field_t alu_count;
  hzd_pkg::field_t jump_count;
  hzd_pkg::field_t branch_count;
  hzd_pkg::field_t memory_count;
  hzd_pkg::field_t other_count;
  hzd_pkg::field_t nop_count;

  hzd_pkg::word_t prv_word = '0;
  bit             prv_seen = 1'b0;
  hzd_pkg::cnt_t  c_total  = '0;
  hzd_pkg::cnt_t  c_alu    = '0;
  hzd_pkg::cnt_t  c_jump   = '0;
  hzd_pkg::cnt_t  c_branch = '0;
  hzd_pkg::cnt_t  c_mem    = '0;
  hzd_pkg::cnt_t  c_other  = '0;
  hzd_pkg::cnt_t  c_nop    = '0;

  emit_t expected_emits[$];
  int    err_count  = 0;
  bit    send_idle  = 1'b1;
  bit    recv_idle  = 1'b1;
  int    burst_left = 0;
  int    stall_tick = 0;
  int    stall_mode = 0;

  riscv_hazard_nop_inserter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .instr_word   (instr_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .is_inserted  (is_inserted),
    .last_of_run  (last_of_run),
    .total_count  (total_count),
    .alu_count    (alu_count),
    .jump_count   (jump_count),
    .branch_count (branch_count),
    .memory_count (memory_count),
    .other_count  (other_count),
    .nop_count    (nop_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic hzd_pkg::word_t mk(logic [6:0] op, hzd_pkg::reg_idx_t rd,
                                        hzd_pkg::reg_idx_t rs1, hzd_pkg::reg_idx_t rs2);
    return {7'b0, rs2, rs1, 3'b0, rd, op};
  endfunction

  function automatic hzd_pkg::kind_t classify(hzd_pkg::word_t w);
    if (w == hzd_pkg::NOP_WORD) return hzd_pkg::K_NOP;
    case (w[6:0])
      hzd_pkg::OP_ALU_R, hzd_pkg::OP_ALU_I: return hzd_pkg::K_ALU;
      hzd_pkg::OP_JAL, hzd_pkg::OP_JALR:    return hzd_pkg::K_JUMP;
      hzd_pkg::OP_BRANCH:                   return hzd_pkg::K_BRANCH;
      hzd_pkg::OP_LOAD, hzd_pkg::OP_STORE:  return hzd_pkg::K_MEM;
      default:                              return hzd_pkg::K_OTHER;
    endcase
  endfunction

  function automatic hzd_pkg::cnt_t bump(hzd_pkg::cnt_t c);
    return (c == hzd_pkg::CNT_MAX) ? c : c + hzd_pkg::cnt_t'(1);
  endfunction

  function automatic emit_t snap(hzd_pkg::word_t w, logic ins, logic last);
    emit_t e;
    e.word   = w;
    e.ins    = ins;
    e.last   = last;
    e.total  = hzd_pkg::field_t'(c_total);
    e.alu    = hzd_pkg::field_t'(c_alu);
    e.jmp    = hzd_pkg::field_t'(c_jump);
    e.branch = hzd_pkg::field_t'(c_branch);
    e.memory = hzd_pkg::field_t'(c_mem);
    e.other  = hzd_pkg::field_t'(c_other);
    e.nop    = hzd_pkg::field_t'(c_nop);
    return e;
  endfunction

  function automatic void queue_emit(emit_t e);
    expected_emits.insert(expected_emits.size(), e);
  endfunction

  task automatic predict_emits(hzd_pkg::word_t w);
    hzd_pkg::kind_t    k;
    logic              hazard;
    hzd_pkg::reg_idx_t rd;
    k = classify(w);
    case (k)
      hzd_pkg::K_ALU:    c_alu    = bump(c_alu);
      hzd_pkg::K_JUMP:   c_jump   = bump(c_jump);
      hzd_pkg::K_BRANCH: c_branch = bump(c_branch);
      hzd_pkg::K_MEM:    c_mem    = bump(c_mem);
      hzd_pkg::K_OTHER:  c_other  = bump(c_other);
      default:           ;
    endcase
    c_total = bump(c_total);
    rd = prv_word[11:7];
    hazard = prv_seen &&
             ((rd == w[19:15]) || ((k != hzd_pkg::K_MEM) && (rd == w[24:20])));
    prv_word = w;
    prv_seen = 1'b1;
    if (hazard) begin
      c_nop = bump(c_nop);
      queue_emit(snap(hzd_pkg::NOP_WORD, 1'b1, 1'b0));
    end
    queue_emit(snap(w, 1'b0, k != hzd_pkg::K_JUMP));
    if (k == hzd_pkg::K_JUMP) begin
      c_nop = bump(c_nop);
      queue_emit(snap(hzd_pkg::NOP_WORD, 1'b1, 1'b1));
    end
  endtask

  function automatic hzd_pkg::word_t gen_word(bit narrow);
    hzd_pkg::word_t w;
    logic [6:0]     op;
    int             sel;
    w = $urandom;
    sel = $urandom_range(0, 19);
    if (sel == 0) return hzd_pkg::NOP_WORD;
    case (sel % 9)
      0:       op = hzd_pkg::OP_ALU_R;
      1:       op = hzd_pkg::OP_ALU_I;
      2:       op = hzd_pkg::OP_JAL;
      3:       op = hzd_pkg::OP_JALR;
      4:       op = hzd_pkg::OP_BRANCH;
      5:       op = hzd_pkg::OP_LOAD;
      6:       op = hzd_pkg::OP_STORE;
      7:       op = OP_LUI;
      default: op = w[6:0];
    endcase
    w[6:0] = op;
    if (narrow) begin
      w[11:7]  = hzd_pkg::reg_idx_t'($urandom_range(0, 3));
      w[19:15] = hzd_pkg::reg_idx_t'($urandom_range(0, 3));
      w[24:20] = hzd_pkg::reg_idx_t'($urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic send_word(hzd_pkg::word_t w);
    int gap;
    @(negedge clk);
    if (send_idle && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (in_stall);
    predict_emits(w);
    burst_left--;
  endtask

  task automatic drain_emits();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_emits.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic cmp(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      err_count++;
      $display("%0t ERROR %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 32 == 0) stall_mode = $urandom_range(0, 3);
    if (!recv_idle) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= (stall_tick % 3 == 0);
        default: out_stall <= ((stall_tick % 16) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    emit_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_emits.size() == 0) begin
        err_count++;
        $display("%0t ERROR unexpected transaction expected none actual %h", $time, out_word);
      end else begin
        e = expected_emits.pop_front();
        cmp("out_word", e.word, out_word);
        cmp("is_inserted", 32'(e.ins), 32'(is_inserted));
        cmp("last_of_run", 32'(e.last), 32'(last_of_run));
        cmp("total_count", 32'(e.total), 32'(total_count));
        cmp("alu_count", 32'(e.alu), 32'(alu_count));
        cmp("jump_count", 32'(e.jmp), 32'(jump_count));
        cmp("branch_count", 32'(e.branch), 32'(branch_count));
        cmp("memory_count", 32'(e.memory), 32'(memory_count));
        cmp("other_count", 32'(e.other), 32'(other_count));
        cmp("nop_count", 32'(e.nop), 32'(nop_count));
      end
    end
  end

  // first word: rd of the cleared previous word matches, but no check applies
  task automatic test_first_word();
    send_word(mk(hzd_pkg::OP_ALU_R, 5'd0, 5'd0, 5'd0));
  endtask

  task automatic test_directed();
    send_word(hzd_pkg::NOP_WORD);
    send_word(hzd_pkg::NOP_WORD);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(mk(hzd_pkg::OP_ALU_I, 5'd5, 5'd1, 5'd2));
    send_word(mk(hzd_pkg::OP_ALU_R, 5'd6, 5'd5, 5'd7));
    send_word(mk(hzd_pkg::OP_ALU_R, 5'd8, 5'd1, 5'd6));
    send_word(mk(hzd_pkg::OP_LOAD, 5'd9, 5'd2, 5'd8));
    send_word(mk(hzd_pkg::OP_STORE, 5'd10, 5'd9, 5'd3));
    send_word(mk(hzd_pkg::OP_BRANCH, 5'd11, 5'd4, 5'd10));
    send_word(mk(hzd_pkg::OP_JAL, 5'd12, 5'd1, 5'd2));
    send_word(mk(hzd_pkg::OP_JALR, 5'd13, 5'd12, 5'd3));
    send_word(mk(hzd_pkg::OP_JAL, 5'd13, 5'd0, 5'd13));
    send_word(mk(OP_LUI, 5'd14, 5'd1, 5'd2));
    send_word(32'h0000_1013);
    send_word(32'h8000_0013);
    send_word(mk(hzd_pkg::OP_STORE, 5'd3, 5'd3, 5'd3));
    send_word(mk(hzd_pkg::OP_LOAD, 5'd31, 5'd31, 5'd31));
    send_word(mk(hzd_pkg::OP_BRANCH, 5'd0, 5'd31, 5'd31));
  endtask

  task automatic test_hazard_stream(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_word(gen_word(1'($urandom_range(0, 1))));
    end
  endtask

  // hold the sender until every queued transaction has come out
  task automatic test_drain_pause();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (20) send_word(gen_word(1'b1));
    drain_emits();
    repeat (20) send_word(gen_word(1'b1));
  endtask

  task automatic test_noise(int n);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (n) send_word($urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_first_word();
    test_directed();
    test_hazard_stream(290);
    test_drain_pause();
    test_noise(120);
    drain_emits();
    repeat (8) @(posedge clk);
    if (expected_emits.size() != 0) begin
      err_count++;
      $display("%0t ERROR missing transactions expected %0d actual 0", $time,
               expected_emits.size());
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
